@@ src/acx_pkg.sv @@
// Shared types, constants and the Ascon round function for the XOF engine.
// No dependencies; imported by every module of the engine.
package acx_pkg;

    localparam int ROUNDS           = 12;
    localparam int RND_W            = 4;
    localparam int DIGEST_WORDS_DEF = 4;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = 1;
    localparam int QCNT_W           = 2;

    localparam logic [63:0] XOF_IV = 64'h00400c0000000000;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef logic [4:0][63:0] state_t;

    typedef enum logic {
        OP_ABSORB = 1'b0,
        OP_FINAL  = 1'b1
    } op_kind_t;

    // one queued request for the permutation side
    typedef struct packed {
        op_kind_t    kind;
        logic [63:0] block;
    } op_t;

    function automatic logic [63:0] rotr64(logic [63:0] v, int n);
        return (v >> n) | (v << (64 - n));
    endfunction

    // one Ascon round, round index r counts up from zero
    function automatic state_t acx_round(state_t s, logic [RND_W-1:0] r);
        logic [63:0] a, b, c, d, e;
        logic [63:0] t0, t1, t2, t3, t4;
        state_t      o;
        a = s[0];
        b = s[1];
        c = s[2];
        d = s[3];
        e = s[4];
        c = c ^ {56'b0, 4'(4'd15 - r), r};
        a = a ^ e;
        e = e ^ d;
        c = c ^ b;
        t0 = ~a & b;
        t1 = ~b & c;
        t2 = ~c & d;
        t3 = ~d & e;
        t4 = ~e & a;
        a = a ^ t1;
        b = b ^ t2;
        c = c ^ t3;
        d = d ^ t4;
        e = e ^ t0;
        b = b ^ a;
        a = a ^ e;
        d = d ^ c;
        c = ~c;
        o[0] = a ^ rotr64(a, 19) ^ rotr64(a, 28);
        o[1] = b ^ rotr64(b, 61) ^ rotr64(b, 39);
        o[2] = c ^ rotr64(c, 1) ^ rotr64(c, 6);
        o[3] = d ^ rotr64(d, 10) ^ rotr64(d, 17);
        o[4] = e ^ rotr64(e, 7) ^ rotr64(e, 41);
        return o;
    endfunction

    // initialized state: IV after one full permutation, folded at elaboration
    function automatic state_t acx_init_state();
        state_t s;
        s    = '0;
        s[0] = XOF_IV;
        for (int i = 0; i < ROUNDS; i++) begin
            s = acx_round(s, RND_W'(i));
        end
        return s;
    endfunction

    localparam state_t INIT_STATE = acx_init_state();

endpackage

@@ src/ascon_xof_hash_engine_top.sv @@
// channel | direction | handshake            | payload
// in      | receive   | in_valid / in_stall   | command, data_byte
// out     | send      | out_valid / out_stall | digest_word, last_word
//
// The front end takes a byte request whenever in_stall is low; every eighth
// byte queues a block, and the permutation unit loads each block and then
// runs 12 rounds on it, so long messages are limited by the round unit.
// Finalize: load of the padded block, then 12 rounds before each output word.
// Reset loads the initialized state directly, with no warm-up permutation.
// in_stall is high only while the two-entry queue is full; out_stall
// holds the output register and, once the next word is ready, the rounds.
//
// Top level of the Ascon-XOF engine; depends on acx_pkg, acx_front,
// acx_fifo and acx_back.
module ascon_xof_hash_engine_top
    import acx_pkg::*;
#(
    parameter int DIGEST_WORDS = DIGEST_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic        last_word
);

    logic q_full, q_push, q_pop, q_valid;
    op_t  q_in_op, q_out_op;

    // request intake and block packing
    acx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .data_byte (data_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (q_in_op)
    );

    // decoupling queue
    acx_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_op   (q_in_op),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_op    (q_out_op)
    );

    // permutation and squeeze
    acx_back #(
        .DIGEST_WORDS (DIGEST_WORDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (q_valid),
        .op          (q_out_op),
        .op_pop      (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .last_word   (last_word)
    );

endmodule

@@ src/acx_front.sv @@
// Front end: accepts byte requests, packs them into 64-bit blocks and
// queues absorb and finalize operations. Depends on acx_pkg.
module acx_front
    import acx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [7:0]  data_byte,
    input  logic        q_full,
    output logic        q_push,
    output op_t         q_op
);

    logic [63:0] buf_reg, buf_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        accept;
    logic [5:0]  shift;
    logic [63:0] merged;

    // stall whenever the queue cannot take an operation
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // byte lane for the next position, big-endian from the top
    assign shift  = {3'(3'd7 - cnt_reg), 3'b000};
    assign merged = buf_reg | (64'(data_byte) << shift);

    // classify the request and build the queued operation
    always_comb
    begin
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        q_push     = 1'b0;
        q_op.kind  = OP_ABSORB;
        q_op.block = merged;
        if (accept)
        begin
            if (command == OP_FINAL)
            begin
                q_push     = 1'b1;
                q_op.kind  = OP_FINAL;
                q_op.block = buf_reg | (64'(PAD_BYTE) << shift);
                buf_next   = '0;
                cnt_next   = '0;
            end
            else if (cnt_reg == 3'd7)
            begin
                q_push   = 1'b1;
                buf_next = '0;
                cnt_next = '0;
            end
            else
            begin
                buf_next = merged;
                cnt_next = cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ src/acx_fifo.sv @@
// Short operation queue between the front end and the permutation engine.
// Depends on acx_pkg for the operation type and depth.
module acx_fifo
    import acx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output op_t  pop_op
);

    op_t               mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_op    = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // occupancy tracking
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // storage, no reset on payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

endmodule

@@ src/acx_back.sv @@
// Back end: holds the 320-bit state, runs one permutation round per cycle,
// squeezes digest words into an output register. Depends on acx_pkg.
module acx_back
    import acx_pkg::*;
#(
    parameter int DIGEST_WORDS = DIGEST_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op_valid,
    input  op_t         op,
    output logic        op_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic        last_word
);

    localparam int WCNT_W = (DIGEST_WORDS > 1) ? $clog2(DIGEST_WORDS) : 1;

    typedef enum logic [3:0] {
        BK_IDLE    = 4'b0001,
        BK_ABSORB  = 4'b0010,
        BK_SQUEEZE = 4'b0100,
        BK_EMIT    = 4'b1000
    } back_state_t;

    back_state_t       st_reg, st_next;
    state_t            s_reg, s_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic [WCNT_W-1:0] word_reg, word_next;
    logic              out_valid_reg, out_valid_next;
    logic [63:0]       word_out_reg, word_out_next;
    logic              last_reg, last_next;
    logic              round_done, emit_go, is_last;

    assign round_done = (rnd_reg == RND_W'(ROUNDS - 1));
    assign emit_go    = (st_reg == BK_EMIT) && (!out_valid_reg || !out_stall);
    assign is_last    = (word_reg == WCNT_W'(DIGEST_WORDS - 1));
    assign op_pop     = (st_reg == BK_IDLE) && op_valid;

    assign out_valid   = out_valid_reg;
    assign digest_word = word_out_reg;
    assign last_word   = last_reg;

    // sequencer over absorb and squeeze phases
    always_comb
    begin
        st_next        = st_reg;
        s_next         = s_reg;
        rnd_next       = rnd_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg && out_stall;
        word_out_next  = word_out_reg;
        last_next      = last_reg;
        unique case (st_reg)
            BK_IDLE:
            begin
                if (op_valid)
                begin
                    s_next[0] = s_reg[0] ^ op.block;
                    rnd_next  = '0;
                    word_next = '0;
                    st_next   = (op.kind == OP_FINAL) ? BK_SQUEEZE : BK_ABSORB;
                end
            end
            BK_ABSORB:
            begin
                s_next   = acx_round(s_reg, rnd_reg);
                rnd_next = rnd_reg + RND_W'(1);
                if (round_done)
                begin
                    st_next = BK_IDLE;
                end
            end
            BK_SQUEEZE:
            begin
                s_next   = acx_round(s_reg, rnd_reg);
                rnd_next = rnd_reg + RND_W'(1);
                if (round_done)
                begin
                    st_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    word_out_next  = s_reg[0];
                    last_next      = is_last;
                    rnd_next       = '0;
                    if (is_last)
                    begin
                        s_next  = INIT_STATE;
                        st_next = BK_IDLE;
                    end
                    else
                    begin
                        word_next = word_reg + WCNT_W'(1);
                        st_next   = BK_SQUEEZE;
                    end
                end
            end
            default:
            begin
                st_next = BK_IDLE;
            end
        endcase
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        word_out_reg <= word_out_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= BK_IDLE;
            s_reg         <= INIT_STATE;
            rnd_reg       <= '0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            s_reg         <= s_next;
            rnd_reg       <= rnd_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/acx_checker.sv @@
// Port-level checks for the Ascon-XOF engine, bound to the top level.
// Depends only on the top-level port names.
module acx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] digest_word,
    input logic        last_word
);

    // reset empties the output register
    a_reset_out: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // reset empties the queue so requests are not stalled
    a_reset_in: assert property (@(posedge clk) !rst_n |-> !in_stall)
        else $error("input stalled during reset");

    // a stalled digest word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(last_word))
        else $error("stalled digest word changed");

endmodule

bind ascon_xof_hash_engine_top acx_checker u_acx_checker (.*);
